// ===== sv/tfb_pkg.sv =====
// Shared types and constants of the telemetry frame builder.
`timescale 1ns / 1ps

package tfb_pkg;

  localparam logic [7:0] SYNC0_BYTE    = 8'hA6;
  localparam logic [7:0] SYNC1_BYTE    = 8'h59;
  localparam logic [7:0] REGADDR_BYTE  = 8'h01;
  localparam logic [7:0] TAIL_Y_BYTE   = 8'h59;
  localparam logic [7:0] TAIL_H_BYTE   = 8'h48;
  localparam logic [7:0] TAIL_T_BYTE   = 8'h54;
  localparam logic [7:0] OVERHEAD_BYTES = 8'd11;

  // Configuration register byte addresses.
  localparam logic [3:0] ADDR_DEVICE  = 4'h0;
  localparam logic [3:0] ADDR_COMMAND = 4'h4;
  localparam logic [3:0] ADDR_LENGTH  = 4'h8;

  // Position of the byte being emitted within the bytes caused by one input item.
  typedef enum logic [3:0] {
    STEP_SYNC0,
    STEP_SYNC1,
    STEP_LEN,
    STEP_DEV,
    STEP_CMD,
    STEP_REG,
    STEP_DATA,
    STEP_SUMHI,
    STEP_SUMLO,
    STEP_Y,
    STEP_H,
    STEP_T
  } step_t;

  // Everything the sequencer needs to emit the bytes of one input item.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  payload;
    logic [7:0]  len_byte;
    logic [7:0]  dev;
    logic [7:0]  cmd;
    logic [15:0] sum;
  } item_t;

endpackage

// ===== sv/tfb_seq.sv =====
// Byte sequencer: holds one item and emits its frame bytes through an output register.
`timescale 1ns / 1ps

module tfb_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  tfb_pkg::item_t item,
  output logic           item_ready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  tfb_pkg::item_t item_r;
  logic           item_v_r;
  tfb_pkg::step_t step_r;
  tfb_pkg::step_t step_nxt;
  logic           out_tvalid_r;
  logic [7:0]     out_tdata_r;
  logic           out_tlast_r;
  logic [7:0]     byte_sel;
  logic           emit;
  logic           final_step;
  logic           load;

  assign emit       = item_v_r && (!out_tvalid_r || out_tready);
  assign final_step = (step_r == tfb_pkg::STEP_T) ||
                      ((step_r == tfb_pkg::STEP_DATA) && !item_r.last);
  assign item_ready = !item_v_r || (emit && final_step);
  assign load       = item_valid && item_ready;

  // Next step within the current item.
  always_comb begin
    case (step_r)
      tfb_pkg::STEP_SYNC0: step_nxt = tfb_pkg::STEP_SYNC1;
      tfb_pkg::STEP_SYNC1: step_nxt = tfb_pkg::STEP_LEN;
      tfb_pkg::STEP_LEN:   step_nxt = tfb_pkg::STEP_DEV;
      tfb_pkg::STEP_DEV:   step_nxt = tfb_pkg::STEP_CMD;
      tfb_pkg::STEP_CMD:   step_nxt = tfb_pkg::STEP_REG;
      tfb_pkg::STEP_REG:   step_nxt = tfb_pkg::STEP_DATA;
      tfb_pkg::STEP_DATA:  step_nxt = tfb_pkg::STEP_SUMHI;
      tfb_pkg::STEP_SUMHI: step_nxt = tfb_pkg::STEP_SUMLO;
      tfb_pkg::STEP_SUMLO: step_nxt = tfb_pkg::STEP_Y;
      tfb_pkg::STEP_Y:     step_nxt = tfb_pkg::STEP_H;
      tfb_pkg::STEP_H:     step_nxt = tfb_pkg::STEP_T;
      default:             step_nxt = tfb_pkg::STEP_DATA;
    endcase
  end

  // Byte selected for the current step.
  always_comb begin
    case (step_r)
      tfb_pkg::STEP_SYNC0: byte_sel = tfb_pkg::SYNC0_BYTE;
      tfb_pkg::STEP_SYNC1: byte_sel = tfb_pkg::SYNC1_BYTE;
      tfb_pkg::STEP_LEN:   byte_sel = item_r.len_byte;
      tfb_pkg::STEP_DEV:   byte_sel = item_r.dev;
      tfb_pkg::STEP_CMD:   byte_sel = item_r.cmd;
      tfb_pkg::STEP_REG:   byte_sel = tfb_pkg::REGADDR_BYTE;
      tfb_pkg::STEP_DATA:  byte_sel = item_r.payload;
      tfb_pkg::STEP_SUMHI: byte_sel = item_r.sum[15:8];
      tfb_pkg::STEP_SUMLO: byte_sel = item_r.sum[7:0];
      tfb_pkg::STEP_Y:     byte_sel = tfb_pkg::TAIL_Y_BYTE;
      tfb_pkg::STEP_H:     byte_sel = tfb_pkg::TAIL_H_BYTE;
      tfb_pkg::STEP_T:     byte_sel = tfb_pkg::TAIL_T_BYTE;
      default:             byte_sel = item_r.payload;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r     <= 1'b0;
      step_r       <= tfb_pkg::STEP_DATA;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load) begin
        item_v_r <= 1'b1;
        step_r   <= item.first ? tfb_pkg::STEP_SYNC0 : tfb_pkg::STEP_DATA;
      end else if (emit && final_step) begin
        item_v_r <= 1'b0;
      end else if (emit) begin
        step_r <= step_nxt;
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
    if (emit) begin
      out_tdata_r <= byte_sel;
      out_tlast_r <= (step_r == tfb_pkg::STEP_T);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== sv/telemetry_frame_builder.sv =====
// Top level of the telemetry frame builder: registers, frame tracking and sequencer.
`timescale 1ns / 1ps
// The first byte caused by an input transaction passes the item register and the output
// register before it shows on out_. Throughput, while out_tready is high: one output byte
// per cycle, and a mid-frame payload byte taken every cycle. A frame's first byte yields
// 7 output bytes, its last 6, a one-byte frame 12.
// Reset (synchronous, rst_n low): registers return to device 2, command 1, length 36,
// the frame position and checksum clear, and no output transaction is pending.

module telemetry_frame_builder #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] payload_byte
  // Output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] frame_byte
  output logic        out_tlast,   // frame_end
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Longest payload that keeps the frame inside the buffer.
  localparam int MAX_LEN = BUFFER_BYTES - 11;

  logic [7:0]     device_r;
  logic [7:0]     command_r;
  logic [6:0]     length_r;
  logic [6:0]     pos_r;
  logic [15:0]    sum_r;

  logic           cfg_wr;
  logic           in_accept;
  logic [7:0]     len_eff;
  logic [7:0]     pos_inc;
  logic           first;
  logic           last;
  logic [15:0]    hdr_sum;
  logic [15:0]    sum_base;
  logic [15:0]    sum_new;
  tfb_pkg::item_t item;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access cycle; reads are
  // combinational since pready is always high.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_r  <= 8'd2;
      command_r <= 8'd1;
      length_r  <= 7'd36;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        tfb_pkg::ADDR_DEVICE:  device_r  <= cfg_pwdata[7:0];
        tfb_pkg::ADDR_COMMAND: command_r <= cfg_pwdata[7:0];
        tfb_pkg::ADDR_LENGTH:  length_r  <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      tfb_pkg::ADDR_DEVICE:  cfg_prdata = {24'd0, device_r};
      tfb_pkg::ADDR_COMMAND: cfg_prdata = {24'd0, command_r};
      tfb_pkg::ADDR_LENGTH:  cfg_prdata = {25'd0, length_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame tracking. The effective length is the register clamped into
  // 1..MAX_LEN; a zero length behaves as a single-byte payload.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (length_r == 7'd0) begin
      len_eff = 8'd1;
    end else if ({2'b00, length_r} > 9'(MAX_LEN)) begin
      len_eff = 8'(MAX_LEN);
    end else begin
      len_eff = {1'b0, length_r};
    end
  end

  assign pos_inc = {1'b0, pos_r} + 8'd1;
  assign first   = (pos_r == 7'd0);
  // The end test uses the live length, so a shortened frame ends on the next byte.
  assign last    = (pos_inc >= len_eff);

  // Checksum of the six header bytes; it seeds the running sum of a new frame.
  assign hdr_sum = 16'(tfb_pkg::SYNC0_BYTE) + 16'(tfb_pkg::SYNC1_BYTE) +
                   16'(8'(len_eff + tfb_pkg::OVERHEAD_BYTES)) + 16'(device_r) +
                   16'(command_r) + 16'(tfb_pkg::REGADDR_BYTE);
  assign sum_base = first ? hdr_sum : sum_r;
  assign sum_new  = sum_base + {8'd0, in_tdata};

  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 7'd0;
      sum_r <= 16'd0;
    end else if (in_accept) begin
      pos_r <= last ? 7'd0 : pos_inc[6:0];
      sum_r <= last ? 16'd0 : sum_new;
    end
  end

  // Header fields are captured with the item, so later device and command writes
  // only affect the next frame's header.
  always_comb begin
    item.first    = first;
    item.last     = last;
    item.payload  = in_tdata;
    item.len_byte = 8'(len_eff + tfb_pkg::OVERHEAD_BYTES);
    item.dev      = device_r;
    item.cmd      = command_r;
    item.sum      = sum_new;
  end

  // ---------------------------------------------------------------------------
  // Byte sequencer. It takes a new item in the cycle its current item sends
  // its final byte, so mid-frame bytes stream at one per cycle while out_tready is high.
  // ---------------------------------------------------------------------------
  tfb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item       (item),
    .item_ready (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/tb_telemetry_frame_builder.sv =====
// Self-checking testbench for the telemetry frame builder: directed table, then random frames.
`timescale 1ns / 1ps

module tb_telemetry_frame_builder;

  localparam int BUFFER_BYTES = 128;
  // Longest payload that still lets header, checksum and tail fit the buffer.
  localparam int MAX_PAYLOAD = BUFFER_BYTES - 11;
  // This address decodes to no register, so a write to it must change nothing.
  localparam logic [3:0] ADDR_UNMAPPED = 4'hC;
  localparam int RANDOM_ITEMS = 140;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] payload_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;    // [7:0] frame_byte
  logic        out_tlast;    // frame_end
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  telemetry_frame_builder #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // One byte of the outgoing frame, as it should show up on the output stream.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // A directed stimulus row is either a register write or one payload transaction.
  // For payload rows that open a frame, the header bytes that are obvious from the
  // register settings can be typed in directly instead of being predicted.
  typedef enum logic {
    ROW_WRITE,
    ROW_PAYLOAD
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  addr;
    logic [31:0] value;
    logic        hdr_typed;
    logic [7:0]  len_byte;
    logic [7:0]  dev_byte;
    logic [7:0]  cmd_byte;
  } stim_row_t;

  // Shadow copy of the block's registers and frame state, kept by the predictor.
  logic [7:0]  device_reg;
  logic [7:0]  command_id;
  logic [6:0]  length_reg;
  logic [6:0]  frame_pos;
  logic [15:0] frame_sum;

  frame_byte_t expected_frame_bytes[$];
  frame_byte_t want;
  int          error_count;

  // Idle and stall switches, changed per phase so that some stretches run at full rate.
  logic in_idle_on;
  logic out_stall_on;
  int   stall_left;

  stim_row_t directed_rows[$];
  int        random_items;
  int        phase;
  int        burst;
  int        eff;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; far above the slowest correct run with every stall at its longest.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Payload length as the block applies it: zero acts as one, and anything past the
  // buffer's room is clamped.
  function automatic int effective_length();
    int len;
    len = int'(length_reg);
    if (len < 1) begin
      len = 1;
    end
    if (len > MAX_PAYLOAD) begin
      len = MAX_PAYLOAD;
    end
    return len;
  endfunction

  function automatic void queue_frame_byte(logic [7:0] b, logic last, logic summed);
    frame_byte_t fb;
    fb.data = b;
    fb.last = last;
    expected_frame_bytes.push_back(fb);
    if (summed) begin
      frame_sum = frame_sum + {8'h00, b};
    end
  endfunction

  // Works out every frame byte that one accepted payload transaction causes. The header
  // goes out ahead of the first payload byte of a frame; the checksum and tail follow
  // the last one. Typed header bytes, when given, take the place of the predicted ones.
  function automatic void build_frame_bytes(logic [7:0] b, logic hdr_typed,
                                            logic [7:0] t_len, logic [7:0] t_dev,
                                            logic [7:0] t_cmd);
    int          len;
    logic [15:0] sum;
    len = effective_length();
    if (frame_pos == 7'd0) begin
      frame_sum = 16'h0000;
      queue_frame_byte(tfb_pkg::SYNC0_BYTE, 1'b0, 1'b1);
      queue_frame_byte(tfb_pkg::SYNC1_BYTE, 1'b0, 1'b1);
      queue_frame_byte(hdr_typed ? t_len : 8'(len) + tfb_pkg::OVERHEAD_BYTES, 1'b0, 1'b1);
      queue_frame_byte(hdr_typed ? t_dev : device_reg, 1'b0, 1'b1);
      queue_frame_byte(hdr_typed ? t_cmd : command_id, 1'b0, 1'b1);
      queue_frame_byte(tfb_pkg::REGADDR_BYTE, 1'b0, 1'b1);
    end
    queue_frame_byte(b, 1'b0, 1'b1);
    frame_pos = frame_pos + 7'd1;
    // The end test uses the length as it stands now, so a length cut below the
    // bytes already taken closes the frame on this byte.
    if (int'(frame_pos) >= len) begin
      sum = frame_sum;
      queue_frame_byte(sum[15:8], 1'b0, 1'b0);
      queue_frame_byte(sum[7:0], 1'b0, 1'b0);
      queue_frame_byte(tfb_pkg::TAIL_Y_BYTE, 1'b0, 1'b0);
      queue_frame_byte(tfb_pkg::TAIL_H_BYTE, 1'b0, 1'b0);
      queue_frame_byte(tfb_pkg::TAIL_T_BYTE, 1'b1, 1'b0);
      frame_pos = 7'd0;
      frame_sum = 16'h0000;
    end
  endfunction

  // Drives one payload transaction, entered and left at a falling edge. The valid
  // stays high between back-to-back transactions unless a gap is chosen.
  task automatic push_payload(input logic [7:0] b, input logic hdr_typed,
                              input logic [7:0] t_len, input logic [7:0] t_dev,
                              input logic [7:0] t_cmd);
    int gap;
    gap = 0;
    if (in_idle_on && $urandom_range(0, 99) < 30) begin
      gap = pick_gap_len();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    build_frame_bytes(b, hdr_typed, t_len, t_dev, t_cmd);
    @(negedge clk);
  endtask

  // Drops the input valid and waits until every predicted byte has come out, so that
  // the block is idle on the output side. Ends at a falling edge.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle; the write lands on the rising edge
  // of the access cycle once pready is seen. Entered and left at a falling edge.
  task automatic write_register(input logic [3:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (addr)
      tfb_pkg::ADDR_DEVICE: begin
        device_reg = data[7:0];
      end
      tfb_pkg::ADDR_COMMAND: begin
        command_id = data[7:0];
      end
      tfb_pkg::ADDR_LENGTH: begin
        length_reg = data[6:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic stim_row_t write_row(logic [3:0] addr, logic [31:0] value);
    stim_row_t r;
    r = '{ROW_WRITE, addr, value, 1'b0, 8'h00, 8'h00, 8'h00};
    return r;
  endfunction

  function automatic stim_row_t payload_row(logic [7:0] b);
    stim_row_t r;
    r = '{ROW_PAYLOAD, 4'h0, {24'h0, b}, 1'b0, 8'h00, 8'h00, 8'h00};
    return r;
  endfunction

  function automatic stim_row_t header_row(logic [7:0] b, logic [7:0] len_b,
                                           logic [7:0] dev_b, logic [7:0] cmd_b);
    stim_row_t r;
    r = '{ROW_PAYLOAD, 4'h0, {24'h0, b}, 1'b1, len_b, dev_b, cmd_b};
    return r;
  endfunction

  // Output back-pressure: random stalls of mixed length while stalls are switched on.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (out_stall_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Every output transaction is checked against the oldest expected frame byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frame_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, got data %h last %b",
                 $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        want = expected_frame_bytes.pop_front();
        if (out_tdata !== want.data) begin
          $display("%0t: frame_byte mismatch, expected %h, got %h",
                   $time, want.data, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: frame_end mismatch, expected %b, got %b",
                   $time, want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = 4'h0;
    cfg_pwdata   = 32'h0;
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    error_count  = 0;
    random_items = 0;
    device_reg   = 8'd2;
    command_id   = 8'd1;
    length_reg   = 7'd36;
    frame_pos    = 7'd0;
    frame_sum    = 16'h0000;

    // Directed rows. Header bytes are typed in where the register values make them
    // obvious; the checksum always comes from the predictor.
    // First frame after reset: length 36 gives a length byte of 47.
    directed_rows.push_back(header_row(8'h00, 8'd47, 8'h02, 8'h01));
    // Cutting the length below the bytes already taken ends the frame on the next byte.
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'd1));
    directed_rows.push_back(payload_row(8'hFF));
    // Single-byte frames: header, payload, checksum and tail all from one transaction.
    directed_rows.push_back(header_row(8'hFF, 8'h0C, 8'h02, 8'h01));
    directed_rows.push_back(payload_row(8'h00));
    directed_rows.push_back(write_row(tfb_pkg::ADDR_DEVICE, 32'h0000_00FF));
    directed_rows.push_back(write_row(tfb_pkg::ADDR_COMMAND, 32'h0000_0000));
    directed_rows.push_back(header_row(8'h55, 8'h0C, 8'hFF, 8'h00));
    // Only the low seven bits hold the length; zero behaves as one.
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'hFFFF_FF80));
    directed_rows.push_back(header_row(8'hAA, 8'h0C, 8'hFF, 8'h00));
    // A length past the buffer's room is clamped to 117, so the length byte is 128.
    directed_rows.push_back(write_row(tfb_pkg::ADDR_DEVICE, 32'h0000_0000));
    directed_rows.push_back(write_row(tfb_pkg::ADDR_COMMAND, 32'h0000_00FF));
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'h0000_007F));
    directed_rows.push_back(header_row(8'h01, 8'h80, 8'h00, 8'hFF));
    // Cutting the length to two ends the frame on its second byte; the sent length byte
    // is not corrected.
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'd2));
    directed_rows.push_back(payload_row(8'h80));
    // Header registers are read when a frame's first payload byte is taken, so a device
    // change in mid-frame shows up in the following frame only.
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'd3));
    directed_rows.push_back(header_row(8'hFE, 8'h0E, 8'h00, 8'hFF));
    directed_rows.push_back(write_row(tfb_pkg::ADDR_DEVICE, 32'h0000_005A));
    directed_rows.push_back(payload_row(8'h7F));
    directed_rows.push_back(payload_row(8'h01));
    // A write to an address with no register behind it changes nothing.
    directed_rows.push_back(write_row(ADDR_UNMAPPED, 32'hFFFF_FFFF));
    directed_rows.push_back(header_row(8'hC3, 8'h0E, 8'h5A, 8'hFF));
    directed_rows.push_back(payload_row(8'h3C));
    directed_rows.push_back(payload_row(8'h99));
    // Largest exact length, then cut back to one so the frame closes right away.
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'd117));
    directed_rows.push_back(header_row(8'h3C, 8'h80, 8'h5A, 8'hFF));
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'd1));
    directed_rows.push_back(payload_row(8'hE7));
    // Two-byte frame: seven bytes out on the first transaction, six on the last.
    directed_rows.push_back(write_row(tfb_pkg::ADDR_LENGTH, 32'd2));
    directed_rows.push_back(header_row(8'h00, 8'h0D, 8'h5A, 8'hFF));
    directed_rows.push_back(payload_row(8'hFF));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        // Registers change only while no frame byte is outstanding.
        wait_for_drain();
        write_register(directed_rows[i].addr, directed_rows[i].value);
      end else begin
        push_payload(directed_rows[i].value[7:0], directed_rows[i].hdr_typed,
                     directed_rows[i].len_byte, directed_rows[i].dev_byte,
                     directed_rows[i].cmd_byte);
      end
    end

    // Random phases: new register settings between phases, then a burst of random
    // payload. Most lengths are small so that many frames complete; one phase runs a
    // frame of the clamped maximum length through to its end. Bursts often stop in
    // mid-frame, so the next phase changes settings inside a frame.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_for_drain();
      in_idle_on   = ($urandom_range(0, 3) != 0);
      out_stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) begin
        write_register(tfb_pkg::ADDR_DEVICE, $urandom());
      end
      if ($urandom_range(0, 1) == 1) begin
        write_register(tfb_pkg::ADDR_COMMAND, $urandom());
      end
      if (phase == 2) begin
        write_register(tfb_pkg::ADDR_LENGTH, $urandom_range(MAX_PAYLOAD, 127));
      end else if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          write_register(tfb_pkg::ADDR_LENGTH, 32'd0);
        end else begin
          write_register(tfb_pkg::ADDR_LENGTH, $urandom_range(1, 12));
        end
      end
      eff = effective_length();
      if (phase == 2) begin
        burst = (int'(frame_pos) < eff) ? eff - int'(frame_pos) : 1;
      end else if (eff > 12) begin
        // A long length left from an earlier phase: take only a few bytes of it.
        burst = $urandom_range(1, 12);
      end else begin
        burst = $urandom_range(1, 2 * eff + 1);
      end
      repeat (burst) begin
        push_payload(8'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00, 8'h00);
        random_items++;
      end
      phase++;
    end

    wait_for_drain();
    // Keep running to catch any stray byte after the last expected one.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
